### hw/rtl/gbn_pkg.sv
// go-back-n sender: shared types, codes and default sizes
// used by the sender top level and its checker
package gbn_pkg;

    localparam int SLOTS_DEF      = 256;
    localparam int MAX_WINDOW_DEF = 16;

    localparam int SEQ_W  = 32;
    localparam int LEN_W  = 9;
    localparam int SLOT_W = 8;
    localparam int WIN_W  = 5;
    localparam int CMD_W  = 2;
    localparam int STAT_W = 2;

    localparam logic [WIN_W-1:0] WINDOW_RESET = 5'd4;

    typedef enum logic [CMD_W-1:0] {
        CMD_SEND    = 2'd0,
        CMD_ACK     = 2'd1,
        CMD_TIMEOUT = 2'd2,
        CMD_INVALID = 2'd3
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK      = 2'd0,
        STAT_FULL    = 2'd1,
        STAT_INVALID = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACK_RD,
        ST_ACK_CMP,
        ST_REL_CHK,
        ST_REL_OUT,
        ST_TO_CHK,
        ST_TO_OUT,
        ST_EMPTY
    } t_state;

endpackage

### hw/rtl/go_back_n_arq_sender_unit.sv
// go-back-n sender controller: descriptor ring, window pointers and sequencer
// depends on gbn_pkg
//
// A command is taken when i_start is high and o_busy low; o_busy then stays high
// until the last result of that command has been shown. Results appear on
// o_valid for one cycle each and cannot be held off. After the accepting cycle,
// a send passes through a release check and then shows one result per released
// frame, and a timeout passes through its own check and then shows one result
// per resent frame; when no frame goes out, either shows a single empty result.
// An ack retires frames one at a time: every retire reads the oldest descriptor
// through the one read port of the ring memory and compares it in the single
// comparator, until a compare stops the retiring or nothing is left outstanding,
// followed by the release phase as for a send. An invalid command gives one
// empty result. At most MAX_WINDOW frames go out per command. The ring memory
// needs no clearing pass after reset.
module go_back_n_arq_sender_unit
    import gbn_pkg::*;
#(
    parameter int SLOTS      = SLOTS_DEF,
    parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [WIN_W-1:0]  i_cfg_wdata,
    input  logic              i_start,
    output logic              o_busy,
    input  logic [CMD_W-1:0]  i_command,
    input  logic [SEQ_W-1:0]  i_frame_seq,
    input  logic [LEN_W-1:0]  i_frame_len,
    input  logic [SEQ_W-1:0]  i_ack_num,
    output logic              o_valid,
    output logic              o_transmit,
    output logic [SLOT_W-1:0] o_slot,
    output logic [LEN_W-1:0]  o_out_len,
    output logic [SEQ_W-1:0]  o_out_seq,
    output logic              o_last,
    output logic [STAT_W-1:0] o_status
);

    localparam int IW = $clog2(SLOTS);
    localparam int QW = $clog2(SLOTS + 1);
    localparam int CW = $clog2(MAX_WINDOW + 1);

    function automatic logic [IW-1:0] inc_idx(input logic [IW-1:0] p);
        logic [IW-1:0] r;
        if (32'(p) == SLOTS - 1) begin
            r = '0;
        end else begin
            r = p + IW'(1);
        end
        return r;
    endfunction

    // descriptor ring
    logic [LEN_W-1:0] mem_len [SLOTS];
    logic [SEQ_W-1:0] mem_seq [SLOTS];

    t_state           r_state, n_state;
    logic [WIN_W-1:0] r_win;
    logic [IW-1:0]    r_oldest, n_oldest;
    logic [IW-1:0]    r_next, n_next;
    logic [IW-1:0]    r_qend, n_qend;
    logic [IW-1:0]    r_p, n_p;
    logic [QW-1:0]    r_q_cnt, n_q_cnt;
    logic [CW-1:0]    r_out_cnt, n_out_cnt;
    logic [CW-1:0]    r_n, n_n;
    t_status          r_status, n_status;
    logic [SEQ_W-1:0] r_ack, n_ack;
    logic [LEN_W-1:0] r_rd_len;
    logic [SEQ_W-1:0] r_rd_seq;
    logic [IW-1:0]    r_rd_idx;

    logic                 accept;
    logic                 full;
    logic                 mem_we;
    logic                 rd_en;
    logic [IW-1:0]        rd_addr;
    logic [CW-1:0]        win_eff;
    logic                 rel_ok;
    logic                 rel_more;
    logic                 to_more;
    logic                 ack_ge;
    logic [IW+SLOT_W-1:0] slot_wide;
    t_cmd                 cmd;

    assign cmd    = t_cmd'(i_command);
    assign accept = i_start && (r_state == ST_IDLE);
    assign full   = (32'(r_q_cnt) == SLOTS);
    assign ack_ge = (r_ack >= r_rd_seq);

    always_comb begin
        if (r_win == '0) begin
            win_eff = CW'(1);
        end else if (32'(r_win) > MAX_WINDOW) begin
            win_eff = CW'(MAX_WINDOW);
        end else begin
            win_eff = CW'(r_win);
        end
    end

    // queued-but-unsent frame present and window open
    assign rel_ok   = (32'(r_q_cnt) > 32'(r_out_cnt)) && (r_out_cnt < win_eff);
    assign rel_more = rel_ok && ((32'(r_n) + 32'd1) < MAX_WINDOW);
    assign to_more  = (32'(r_n) + 32'd1) < 32'(r_out_cnt);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    case (cmd)
                        CMD_SEND:    n_state = ST_REL_CHK;
                        CMD_ACK:     n_state = ST_ACK_RD;
                        CMD_TIMEOUT: n_state = ST_TO_CHK;
                        default:     n_state = ST_EMPTY;
                    endcase
                end
            end
            ST_ACK_RD: begin
                n_state = (r_out_cnt != '0) ? ST_ACK_CMP : ST_REL_CHK;
            end
            ST_ACK_CMP: begin
                n_state = ack_ge ? ST_ACK_RD : ST_REL_CHK;
            end
            ST_REL_CHK: begin
                n_state = rel_ok ? ST_REL_OUT : ST_EMPTY;
            end
            ST_REL_OUT: begin
                n_state = rel_more ? ST_REL_OUT : ST_IDLE;
            end
            ST_TO_CHK: begin
                n_state = (r_out_cnt != '0) ? ST_TO_OUT : ST_EMPTY;
            end
            ST_TO_OUT: begin
                n_state = to_more ? ST_TO_OUT : ST_IDLE;
            end
            ST_EMPTY: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // datapath controls
    always_comb begin
        n_oldest  = r_oldest;
        n_next    = r_next;
        n_qend    = r_qend;
        n_p       = r_p;
        n_q_cnt   = r_q_cnt;
        n_out_cnt = r_out_cnt;
        n_n       = r_n;
        n_status  = r_status;
        n_ack     = r_ack;
        mem_we    = 1'b0;
        rd_en     = 1'b0;
        rd_addr   = r_next;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_n      = '0;
                    n_ack    = i_ack_num;
                    n_status = STAT_OK;
                    if (cmd == CMD_INVALID) begin
                        n_status = STAT_INVALID;
                    end else if (cmd == CMD_SEND) begin
                        if (full) begin
                            n_status = STAT_FULL;
                        end else begin
                            mem_we  = 1'b1;
                            n_qend  = inc_idx(r_qend);
                            n_q_cnt = r_q_cnt + QW'(1);
                        end
                    end
                end
            end
            ST_ACK_RD: begin
                if (r_out_cnt != '0) begin
                    rd_en   = 1'b1;
                    rd_addr = r_oldest;
                end
            end
            ST_ACK_CMP: begin
                if (ack_ge) begin
                    n_oldest  = inc_idx(r_oldest);
                    n_out_cnt = r_out_cnt - CW'(1);
                    n_q_cnt   = r_q_cnt - QW'(1);
                end
            end
            ST_REL_CHK: begin
                if (rel_ok) begin
                    rd_en     = 1'b1;
                    rd_addr   = r_next;
                    n_next    = inc_idx(r_next);
                    n_out_cnt = r_out_cnt + CW'(1);
                end
            end
            ST_REL_OUT: begin
                if (rel_more) begin
                    rd_en     = 1'b1;
                    rd_addr   = r_next;
                    n_next    = inc_idx(r_next);
                    n_out_cnt = r_out_cnt + CW'(1);
                    n_n       = r_n + CW'(1);
                end
            end
            ST_TO_CHK: begin
                if (r_out_cnt != '0) begin
                    rd_en   = 1'b1;
                    rd_addr = r_oldest;
                    n_p     = inc_idx(r_oldest);
                end
            end
            ST_TO_OUT: begin
                if (to_more) begin
                    rd_en   = 1'b1;
                    rd_addr = r_p;
                    n_p     = inc_idx(r_p);
                    n_n     = r_n + CW'(1);
                end
            end
            default: begin
            end
        endcase
    end

    // result ports
    assign slot_wide = {SLOT_W'(0), r_rd_idx};

    always_comb begin
        o_valid    = 1'b0;
        o_transmit = 1'b0;
        o_last     = 1'b0;
        o_slot     = '0;
        o_out_len  = '0;
        o_out_seq  = '0;
        o_status   = r_status;
        case (r_state)
            ST_REL_OUT, ST_TO_OUT: begin
                o_valid    = 1'b1;
                o_transmit = 1'b1;
                o_slot     = slot_wide[SLOT_W-1:0];
                o_out_len  = r_rd_len;
                o_out_seq  = r_rd_seq;
                o_last     = (r_state == ST_REL_OUT) ? !rel_more : !to_more;
            end
            ST_EMPTY: begin
                o_valid = 1'b1;
                o_last  = 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign o_busy = (r_state != ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_win     <= WINDOW_RESET;
            r_oldest  <= '0;
            r_next    <= '0;
            r_qend    <= '0;
            r_q_cnt   <= '0;
            r_out_cnt <= '0;
        end else begin
            r_state   <= n_state;
            r_oldest  <= n_oldest;
            r_next    <= n_next;
            r_qend    <= n_qend;
            r_q_cnt   <= n_q_cnt;
            r_out_cnt <= n_out_cnt;
            if (i_cfg_we) begin
                r_win <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_p      <= n_p;
        r_n      <= n_n;
        r_status <= n_status;
        r_ack    <= n_ack;
    end

    // ring memory, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem_len[r_qend] <= i_frame_len;
            mem_seq[r_qend] <= i_frame_seq;
        end
        if (rd_en) begin
            r_rd_len <= mem_len[rd_addr];
            r_rd_seq <= mem_seq[rd_addr];
            r_rd_idx <= rd_addr;
        end
    end

endmodule

### hw/rtl/gbn_checker.sv
// port-level checks on the go-back-n sender, attached by bind
// depends on gbn_pkg and go_back_n_arq_sender_unit
module gbn_checker
    import gbn_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_start,
    input logic              o_busy,
    input logic              o_valid,
    input logic              o_transmit,
    input logic [SLOT_W-1:0] o_slot,
    input logic [LEN_W-1:0]  o_out_len,
    input logic [SEQ_W-1:0]  o_out_seq,
    input logic              o_last
);

    // a taken command always sets the block busy
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start && !o_busy |=> o_busy)
        else $error("command taken but block not busy");

    // results only while a command is in progress
    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_busy)
        else $error("result shown while idle");

    // the last item of a command frees the block
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last |=> !o_busy)
        else $error("block still busy after last item");

    // an empty item stands alone and carries no descriptor
    a_empty_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_transmit |-> o_last && (o_slot == '0) && (o_out_len == '0)
            && (o_out_seq == '0))
        else $error("malformed empty item");

endmodule

bind go_back_n_arq_sender_unit gbn_checker u_gbn_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_start    (i_start),
    .o_busy     (o_busy),
    .o_valid    (o_valid),
    .o_transmit (o_transmit),
    .o_slot     (o_slot),
    .o_out_len  (o_out_len),
    .o_out_seq  (o_out_seq),
    .o_last     (o_last)
);
